// ----- hdl/multichannel_conv2d_valid_defines.svh -----
// Assertion macros used by the checker file.
`ifndef MULTICHANNEL_CONV2D_VALID_DEFINES_SVH
`define MULTICHANNEL_CONV2D_VALID_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mcconv_pkg.sv -----
// Shared types, opcodes and register indexes of the convolution block.
`default_nettype none

package mcconv_pkg;

  localparam int unsigned ADDR_W     = 13;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned FILT_W     = 4;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned IMG_W      = 6;
  localparam int unsigned KS_W       = 3;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned FC_W       = 5;
  localparam int unsigned IN_TDATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [1:0] OP_WR_SAMPLE = 2'd0;
  localparam logic [1:0] OP_WR_WEIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE   = 2'd2;
  localparam logic [1:0] OP_NOP       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIDE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT  = 3'd3;

  typedef struct packed {
    logic wr_sample;
    logic wr_weight;
    logic setup;
    logic base;
    logic issue;
    logic load_err;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic weight_ok;
    logic bad;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/mcconv_ctrl.sv -----
// Controller state machine: decodes accepted beats and sequences a compute.
`default_nettype none

module mcconv_ctrl
  import mcconv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] op_i,
  output logic            in_ready_o,
  input  wire status_t    sts_i,
  output cmd_t            cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BASE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_WR_SAMPLE: begin
              cmd_o.wr_sample = sts_i.sample_ok;
              cmd_o.load_err  = !sts_i.sample_ok;
            end
            OP_WR_WEIGHT: begin
              cmd_o.wr_weight = sts_i.weight_ok;
              cmd_o.load_err  = !sts_i.weight_ok;
            end
            OP_COMPUTE: begin
              if (sts_i.bad) begin
                cmd_o.load_err = 1'b1;
              end else begin
                cmd_o.setup = 1'b1;
                state_d     = ST_BASE;
              end
            end
            OP_NOP: begin
              cmd_o = '0;
            end
          endcase
        end
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the read and multiply stages to empty into the accumulator
        if (!sts_i.pipe_busy) begin
          cmd_o.load_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mcconv_dpath.sv -----
// Datapath: registers, sample and weight memories, address walk, MAC, output register.
`default_nettype none

module mcconv_dpath
  import mcconv_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_SIDE  = 32,
  parameter int unsigned MAX_KERNEL_SIDE = 7,
  parameter int unsigned MAX_CHANNELS    = 8,
  parameter int unsigned MAX_FILTERS     = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [ADDR_W-1:0]     addr_i,
  input  wire logic [VAL_W-1:0]      value_i,
  input  wire logic [FILT_W-1:0]     out_filter_i,
  input  wire logic [POS_W-1:0]      out_row_i,
  input  wire logic [POS_W-1:0]      out_col_i,
  input  wire cmd_t                  cmd_i,
  output status_t                    sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [RES_W-1:0]           result_o,
  output logic                       error_o
);

  localparam int unsigned SDEPTH = MAX_CHANNELS * MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
  localparam int unsigned WDEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL_SIDE
                                   * MAX_KERNEL_SIDE;
  localparam int unsigned SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int unsigned WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  // configuration registers
  logic [IMG_W-1:0] img_q;
  logic [KS_W-1:0]  ks_q;
  logic [CH_W-1:0]  ch_q;
  logic [FC_W-1:0]  fcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_q  <= IMG_W'(32);
      ks_q   <= KS_W'(3);
      ch_q   <= CH_W'(1);
      fcnt_q <= FC_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_SIDE:    img_q  <= cfg_data_i[IMG_W-1:0];
        CFG_KERNEL_SIDE:   ks_q   <= cfg_data_i[KS_W-1:0];
        CFG_CHANNEL_COUNT: ch_q   <= cfg_data_i[CH_W-1:0];
        CFG_FILTER_COUNT:  fcnt_q <= cfg_data_i[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // range checks on the registers and on the beat being offered
  logic             cfg_bad, coord_bad;
  logic [IMG_W-1:0] osz;

  assign cfg_bad = (img_q == '0) || (32'(img_q) > MAX_IMAGE_SIDE)
                || (ks_q == '0) || (32'(ks_q) > MAX_KERNEL_SIDE)
                || (ch_q == '0) || (32'(ch_q) > MAX_CHANNELS)
                || (fcnt_q == '0) || (32'(fcnt_q) > MAX_FILTERS)
                || (IMG_W'(ks_q) > img_q);
  assign osz       = img_q - IMG_W'(ks_q) + IMG_W'(1);
  assign coord_bad = (FC_W'(out_filter_i) >= fcnt_q)
                  || (IMG_W'(out_row_i) >= osz) || (IMG_W'(out_col_i) >= osz);

  // setup products, taken when a good compute beat is accepted
  logic [SAW-1:0] s2_q, rowoff_q;
  logic [5:0]     k2_q;
  logic [7:0]     fc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      s2_q     <= SAW'(img_q) * SAW'(img_q);
      rowoff_q <= SAW'(12'(out_row_i) * 12'(img_q) + 12'(out_col_i));
      k2_q     <= 6'(ks_q) * 6'(ks_q);
      fc_q     <= 8'(out_filter_i) * 8'(ch_q);
    end
  end

  // address walk: channel outermost, then kernel row, then kernel column
  logic [SAW-1:0]  sa_q, row_start_q, chan_start_q;
  logic [WAW-1:0]  wa_q;
  logic [KS_W-1:0] kc_q, kr_q;
  logic [CH_W-1:0] c_q;
  logic            kc_end, kr_end;

  assign kc_end = (kc_q == ks_q - KS_W'(1));
  assign kr_end = (kr_q == ks_q - KS_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kc_q <= '0;
      kr_q <= '0;
      c_q  <= '0;
    end else if (cmd_i.base) begin
      kc_q <= '0;
      kr_q <= '0;
      c_q  <= '0;
    end else if (cmd_i.issue) begin
      if (!kc_end) begin
        kc_q <= kc_q + KS_W'(1);
      end else begin
        kc_q <= '0;
        if (!kr_end) begin
          kr_q <= kr_q + KS_W'(1);
        end else begin
          kr_q <= '0;
          c_q  <= c_q + CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.base) begin
      sa_q         <= rowoff_q;
      row_start_q  <= rowoff_q;
      chan_start_q <= rowoff_q;
      wa_q         <= WAW'(fc_q) * WAW'(k2_q);
    end else if (cmd_i.issue) begin
      wa_q <= wa_q + WAW'(1);
      if (!kc_end) begin
        sa_q <= sa_q + SAW'(1);
      end else if (!kr_end) begin
        row_start_q <= row_start_q + SAW'(img_q);
        sa_q        <= row_start_q + SAW'(img_q);
      end else begin
        chan_start_q <= chan_start_q + s2_q;
        row_start_q  <= chan_start_q + s2_q;
        sa_q         <= chan_start_q + s2_q;
      end
    end
  end

  // memories with registered reads
  logic [VAL_W-1:0]        smem [SDEPTH];
  logic [VAL_W-1:0]        wmem [WDEPTH];
  logic signed [VAL_W-1:0] x_q, w_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sample) begin
      smem[SAW'(addr_i)] <= value_i;
    end
    if (cmd_i.issue) begin
      x_q <= smem[sa_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_weight) begin
      wmem[WAW'(addr_i)] <= value_i;
    end
    if (cmd_i.issue) begin
      w_q <= wmem[wa_q];
    end
  end

  // multiply, then accumulate with wrap at the accumulator width
  logic                    v1_q, v2_q;
  logic signed [RES_W-1:0] p_q;
  logic [ACC_W-1:0]        acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_q <= x_q * w_q;
    end
    if (cmd_i.base) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + {{(ACC_W-RES_W){p_q[RES_W-1]}}, p_q};
    end
  end

  // saturate to the result width
  logic             fits;
  logic [RES_W-1:0] sat;

  assign fits = (&acc_q[ACC_W-1:RES_W-1]) || !(|acc_q[ACC_W-1:RES_W-1]);
  assign sat  = fits ? acc_q[RES_W-1:0]
              : (acc_q[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}});

  // output register
  logic             out_valid_q;
  logic [RES_W-1:0] result_q;
  logic             error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_err || cmd_i.load_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      result_q <= '0;
      error_q  <= 1'b1;
    end else if (cmd_i.load_res) begin
      result_q <= sat;
      error_q  <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign error_o     = error_q;

  assign sts_o.sample_ok  = 32'(addr_i) < SDEPTH;
  assign sts_o.weight_ok  = 32'(addr_i) < WDEPTH;
  assign sts_o.bad        = cfg_bad || coord_bad;
  assign sts_o.last_issue = kc_end && kr_end && (c_q == ch_q - CH_W'(1));
  assign sts_o.pipe_busy  = v1_q || v2_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ----- hdl/multichannel_conv2d_valid.sv -----
// Top level of the multi-channel valid 2-D convolution block.
//
//  Channel   Dir  Handshake                       Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser: op; tdata: addr, value,
//                                                 out_filter, out_row, out_col
//  m_axis    out  m_axis_tvalid / m_axis_tready   tuser: error; tdata: result
//  cfg       in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
//  A sample or weight write lands at the edge that accepts it; a bad write
//  address returns one error beat. A compute beat runs a base step, one issue
//  per kernel tap and channel through one read port per memory, and a drain
//  while the last read and product reach the accumulator, then loads its
//  result. The input is held from the accepting edge until that result loads.
//  Reset clears control state and sets the registers to their defaults; the
//  memories are not cleared. A stalled result holds in the output register;
//  the next input beat is taken as soon as that register is free or draining.
`default_nettype none

module multichannel_conv2d_valid
  import mcconv_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_SIDE  = 32,
  parameter int unsigned MAX_KERNEL_SIDE = 7,
  parameter int unsigned MAX_CHANNELS    = 8,
  parameter int unsigned MAX_FILTERS     = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input beats
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // addr[12:0], value[28:13], out_filter[32:29], out_row[37:33], out_col[42:38], zeros
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  // op[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  // result beats
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // result[31:0]
  output logic [RES_W-1:0]           m_axis_tdata,
  // error[0]
  output logic                       m_axis_tuser,
  // register writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t sts;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  mcconv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .op_i       (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcconv_dpath #(
    .MAX_IMAGE_SIDE  (MAX_IMAGE_SIDE),
    .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_FILTERS     (MAX_FILTERS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .addr_i       (s_axis_tdata[12:0]),
    .value_i      (s_axis_tdata[28:13]),
    .out_filter_i (s_axis_tdata[32:29]),
    .out_row_i    (s_axis_tdata[37:33]),
    .out_col_i    (s_axis_tdata[42:38]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (m_axis_tdata),
    .error_o      (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- hdl/mcconv_checker.sv -----
// Port-level checker for the convolution block, bound to the top level.
`default_nettype none
`include "multichannel_conv2d_valid_defines.svh"

module mcconv_checker
  import mcconv_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [1:0]       s_axis_tuser,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [RES_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tuser
);

  logic in_beat, out_stall;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `MCC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `MCC_ASSERT_SAME(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error beat with nonzero result")
  `MCC_ASSERT_NEXT(a_busy_after_compute, in_beat && (s_axis_tuser == OP_COMPUTE), !s_axis_tready || (m_axis_tvalid && m_axis_tuser), "input ready right after a good compute")
  `MCC_ASSERT_NEXT(a_nop_silent, in_beat && (s_axis_tuser == OP_NOP) && !m_axis_tvalid, !m_axis_tvalid, "nop produced a result")

endmodule

bind multichannel_conv2d_valid mcconv_checker u_checker (.*);

`default_nettype wire
